/* sv/msipd_pkg.sv */
// ============================================================================
// msipd_pkg
// Shared widths, codes and types of the MSI page directory.
// ============================================================================
package msipd_pkg;

   // directory geometry
   localparam int PAGES   = 4096;
   localparam int NODES   = 64;

   // field widths
   localparam int FUNC_W  = 2;
   localparam int PAGE_W  = 12;
   localparam int NODE_W  = 6;
   localparam int STATE_W = 2;
   localparam int COUNT_W = 13;
   localparam int MASK_W  = 64;
   localparam int ADDR_W  = (PAGES > 1) ? $clog2(PAGES) : 1;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

   // MSI state codes
   localparam logic [STATE_W-1:0] ST_INVALID  = 2'd0;
   localparam logic [STATE_W-1:0] ST_SHARED   = 2'd1;
   localparam logic [STATE_W-1:0] ST_MODIFIED = 2'd2;

   // reset value of the page count register
   localparam logic [COUNT_W-1:0] PAGE_COUNT_RESET = COUNT_W'(4096);

   // bits of the sharer map that name real nodes
   localparam logic [MASK_W-1:0] NODE_MASK =
      MASK_W'((65'(1) << NODES) - 65'(1));

   // one directory entry as stored in memory
   typedef struct packed {
      logic [STATE_W-1:0] state;
      logic [NODE_W-1:0]  owner;
      logic [MASK_W-1:0]  sharers;
   } dir_entry_type;

   localparam int ENTRY_W = $bits(dir_entry_type);

   // one result beat
   typedef struct packed {
      logic               accepted;
      logic [STATE_W-1:0] prior_state;
      logic [NODE_W-1:0]  prior_owner;
      logic [MASK_W-1:0]  invalidate_mask;
      logic [STATE_W-1:0] new_state;
      logic [NODE_W-1:0]  new_owner;
      logic [MASK_W-1:0]  new_sharers;
   } rsp_type;

   // one-hot bit of a node in the sharer map
   function automatic logic [MASK_W-1:0] node_bit(input logic [NODE_W-1:0] n);
      node_bit = MASK_W'(1) << n;
   endfunction

endpackage

/* sv/msipd_req_if.sv */
// ============================================================================
// msipd_req_if
// Request channel: function, page index and requesting node.
// ============================================================================
interface msipd_req_if;
   import msipd_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [PAGE_W-1:0] page;
   logic [NODE_W-1:0] node;

   modport source (output valid, output func, output page, output node, input ready);
   modport sink   (input valid, input func, input page, input node, output ready);
endinterface

/* sv/msipd_rsp_if.sv */
// ============================================================================
// msipd_rsp_if
// Response channel: prior and updated directory entry plus invalidate mask.
// ============================================================================
interface msipd_rsp_if;
   import msipd_pkg::*;

   logic               valid;
   logic               ready;
   logic               accepted;
   logic [STATE_W-1:0] prior_state;
   logic [NODE_W-1:0]  prior_owner;
   logic [MASK_W-1:0]  invalidate_mask;
   logic [STATE_W-1:0] new_state;
   logic [NODE_W-1:0]  new_owner;
   logic [MASK_W-1:0]  new_sharers;

   modport source (output valid, output accepted, output prior_state, output prior_owner,
                   output invalidate_mask, output new_state, output new_owner,
                   output new_sharers, input ready);
   modport sink   (input valid, input accepted, input prior_state, input prior_owner,
                   input invalidate_mask, input new_state, input new_owner,
                   input new_sharers, output ready);
endinterface

/* sv/msipd_csr_if.sv */
// ============================================================================
// msipd_csr_if
// Configuration write channel for the page count register.
// ============================================================================
interface msipd_csr_if;
   import msipd_pkg::*;

   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] page_count;

   modport source (output valid, output page_count, input ready);
   modport sink   (input valid, input page_count, output ready);
endinterface

/* sv/msipd_ram.sv */
// ============================================================================
// msipd_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module msipd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port; data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

/* sv/msipd_update.sv */
// ============================================================================
// msipd_update
// MSI transition of one directory entry: range check, next entry, response.
// ============================================================================
module msipd_update (
   input  logic [msipd_pkg::FUNC_W-1:0]  func,
   input  logic [msipd_pkg::PAGE_W-1:0]  page,
   input  logic [msipd_pkg::NODE_W-1:0]  node,
   input  logic [msipd_pkg::COUNT_W-1:0] page_count,
   input  msipd_pkg::dir_entry_type      cur,
   output logic                          wr_en,
   output msipd_pkg::rsp_type            result
);
   import msipd_pkg::*;

   logic              in_range;
   logic [MASK_W-1:0] holders;
   logic [MASK_W-1:0] node_onehot;

   // page must be below both the configured count and the store depth
   assign in_range = ({1'b0, page} < page_count) &&
                     (32'(page) < 32'(PAGES)) &&
                     (32'(node) < 32'(NODES));

   assign node_onehot = node_bit(node);

   // nodes holding a copy before a write; owner zero means nobody
   always_comb begin
      holders = '0;
      if (cur.state == ST_MODIFIED) begin
         if (cur.owner != '0) begin
            holders = node_bit(cur.owner);
         end
      end else if (cur.state == ST_SHARED) begin
         holders = cur.sharers;
      end
   end

   // next entry and response
   always_comb begin
      result.accepted        = 1'b1;
      result.prior_state     = cur.state;
      result.prior_owner     = cur.owner;
      result.invalidate_mask = '0;
      result.new_state       = cur.state;
      result.new_owner       = cur.owner;
      result.new_sharers     = cur.sharers;
      wr_en                  = 1'b0;
      case (func)
         FUNC_READ: begin
            wr_en              = 1'b1;
            result.new_state   = ST_SHARED;
            result.new_owner   = '0;
            if (cur.state == ST_MODIFIED) begin
               result.new_sharers = (node_bit(cur.owner) | node_onehot) & NODE_MASK;
            end else begin
               result.new_sharers = (cur.sharers | node_onehot) & NODE_MASK;
            end
         end
         FUNC_WRITE: begin
            wr_en                  = 1'b1;
            result.invalidate_mask = holders & ~node_onehot & NODE_MASK;
            result.new_state       = ST_MODIFIED;
            result.new_owner       = node;
            result.new_sharers     = '0;
         end
         default: begin
            // lookup and unused code: report only
            wr_en = 1'b0;
         end
      endcase
      // rejected request: all fields zero, entry untouched
      if (!in_range) begin
         result = '0;
         wr_en  = 1'b0;
      end
   end

endmodule

/* sv/msi_page_directory.sv */
// ============================================================================
// msi_page_directory
// MSI coherence directory over a page-indexed entry memory.
// ============================================================================
// Each request beat is handled in order: the entry is read from a RAM with
// registered read data, then the MSI update is written back and the response
// beat is loaded into an output register once that register is empty or being
// read. A new request is taken in the cycle after that, also while the
// previous response still waits. This follows from the read-then-write-back
// of the single entry RAM. After reset the block sweeps the RAM to invalid,
// owner 0, empty sharers, one entry a cycle, and accepts no request until it
// is done; page count writes are taken at any time.
// ============================================================================
module msi_page_directory (
   input  logic         clock,
   input  logic         reset,
   msipd_req_if.sink    req_port,
   msipd_rsp_if.source  rsp_port,
   msipd_csr_if.sink    csr_port
);
   import msipd_pkg::*;

   // configuration
   logic [COUNT_W-1:0] page_count_ff, page_count_in;

   // clearing sweep
   logic              clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0] clr_idx_ff, clr_idx_in;

   // request held while the entry is read
   logic              busy_ff, busy_in;
   logic [FUNC_W-1:0] func_ff;
   logic [PAGE_W-1:0] page_ff;
   logic [NODE_W-1:0] node_ff;

   // response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   // datapath
   logic          req_beat;
   logic          finish;
   logic          upd_wr_en;
   rsp_type       upd_result;
   dir_entry_type rd_entry;
   dir_entry_type wr_entry;
   logic          ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;

   // handshakes
   assign csr_port.ready = 1'b1;
   assign req_port.ready = !clr_busy_ff && !busy_ff;
   assign req_beat       = req_port.valid && req_port.ready;
   assign finish         = busy_ff && (!rsp_valid_ff || rsp_port.ready);

   // entry store
   msipd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PAGES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (wr_entry),
      .rd_en   (req_beat),
      .rd_addr (req_port.page[ADDR_W-1:0]),
      .rd_data (rd_entry)
   );

   // MSI transition on the fetched entry
   msipd_update u_update (
      .func       (func_ff),
      .page       (page_ff),
      .node       (node_ff),
      .page_count (page_count_ff),
      .cur        (rd_entry),
      .wr_en      (upd_wr_en),
      .result     (upd_result)
   );

   // write port: clearing sweep or write-back
   always_comb begin
      if (clr_busy_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_idx_ff;
         wr_entry    = '0;
      end else begin
         ram_wr_en   = finish && upd_wr_en;
         ram_wr_addr = page_ff[ADDR_W-1:0];
         wr_entry.state   = upd_result.new_state;
         wr_entry.owner   = upd_result.new_owner;
         wr_entry.sharers = upd_result.new_sharers;
      end
   end

   // next-state logic
   always_comb begin
      page_count_in = csr_port.valid ? csr_port.page_count : page_count_ff;

      clr_idx_in  = clr_idx_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (32'(clr_idx_ff) == PAGES - 1) begin
            clr_busy_in = 1'b0;
         end
      end

      busy_in = busy_ff;
      if (req_beat) begin
         busy_in = 1'b1;
      end else if (finish) begin
         busy_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         page_count_ff <= PAGE_COUNT_RESET;
         clr_busy_ff   <= 1'b1;
         clr_idx_ff    <= '0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         page_count_ff <= page_count_in;
         clr_busy_ff   <= clr_busy_in;
         clr_idx_ff    <= clr_idx_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         func_ff <= req_port.func;
         page_ff <= req_port.page;
         node_ff <= req_port.node;
      end
      if (finish) begin
         rsp_data_ff <= upd_result;
      end
   end

   // response beat
   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.accepted        = rsp_data_ff.accepted;
   assign rsp_port.prior_state     = rsp_data_ff.prior_state;
   assign rsp_port.prior_owner     = rsp_data_ff.prior_owner;
   assign rsp_port.invalidate_mask = rsp_data_ff.invalidate_mask;
   assign rsp_port.new_state       = rsp_data_ff.new_state;
   assign rsp_port.new_owner       = rsp_data_ff.new_owner;
   assign rsp_port.new_sharers     = rsp_data_ff.new_sharers;

endmodule
